// File: rtl/rtpc_pkg.sv
// Package for the resistive touch point calculator.
// Holds register indexes, reset values, widths and shared types; no dependencies.
`timescale 1ns / 1ps
package rtpc_pkg;

  localparam int FullCode = 1023;

  localparam logic [2:0] RegPlate = 3'd0;
  localparam logic [2:0] RegTol = 3'd1;
  localparam logic [2:0] RegWidth = 3'd2;
  localparam logic [2:0] RegHeight = 3'd3;
  localparam logic [2:0] RegPfs = 3'd4;

  localparam logic [11:0] PlateReset = 12'd300;
  localparam logic [9:0] TolReset = 10'd10;
  localparam logic [11:0] WidthReset = 12'd320;
  localparam logic [11:0] HeightReset = 12'd240;
  localparam logic [9:0] PfsReset = 10'd100;

  localparam int QueueDepth = 4;

  // Classified item handed from front to back.
  typedef struct packed {
    logic       ok;
    logic       z1_zero;
    logic [9:0] x;
    logic [9:0] y;
    logic [9:0] z1;
    logic [9:0] z2;
  } item_t;

endpackage

// File: rtl/rtpc_front.sv
// Front part: checks sample pair agreement and forms raw coordinates.
// Depends on rtpc_pkg.
`timescale 1ns / 1ps
module rtpc_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [9:0]           x_sample_first,
  input  logic [9:0]           x_sample_second,
  input  logic [9:0]           y_sample_first,
  input  logic [9:0]           y_sample_second,
  input  logic [9:0]           z_one_sample,
  input  logic [9:0]           z_two_sample,
  input  logic [9:0]           tol,
  output logic                 item_valid,
  output rtpc_pkg::item_t      item
);

  logic [9:0] dx, dy;

  always_comb begin
    dx = (x_sample_first > x_sample_second) ? x_sample_first - x_sample_second
                                            : x_sample_second - x_sample_first;
    dy = (y_sample_first > y_sample_second) ? y_sample_first - y_sample_second
                                            : y_sample_second - y_sample_first;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= start;
    end
    item.ok <= (dx <= tol) && (dy <= tol);
    item.z1_zero <= (z_one_sample == 10'd0);
    item.x <= 10'd1023 - x_sample_second;
    item.y <= 10'd1023 - y_sample_second;
    item.z1 <= z_one_sample;
    item.z2 <= z_two_sample;
  end

endmodule

// File: rtl/rtpc_queue.sv
// Short queue between the front and back parts.
// Depends on rtpc_pkg.
`timescale 1ns / 1ps
module rtpc_queue #(
  parameter int Depth = rtpc_pkg::QueueDepth
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rtpc_pkg::item_t din,
  input  logic            pop,
  output logic            not_empty,
  output logic            full,
  output rtpc_pkg::item_t dout
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  rtpc_pkg::item_t mem [Depth];
  logic [AW-1:0] wp, rp;
  logic [AW:0] count;

  assign not_empty = (count != '0);
  assign full = (count == (AW+1)'(Depth));
  assign dout = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (push) wp <= (wp == AW'(Depth - 1)) ? '0 : wp + 1'b1;
      if (pop) rp <= (rp == AW'(Depth - 1)) ? '0 : rp + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
    if (push) mem[wp] <= din;
  end

endmodule

// File: rtl/rtpc_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// No package dependency; tag travels with each beat.
`timescale 1ns / 1ps
module rtpc_div #(
  parameter int NW = 32,
  parameter int DW = 20,
  parameter int TW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [TW-1:0] tag_in,
  output logic          out_valid,
  output logic [NW-1:0] quot,
  output logic [TW-1:0] tag_out
);

  logic [NW-1:0] q   [NW+1];
  logic [DW:0]   rem [NW+1];
  logic [DW-1:0] d   [NW+1];
  logic [TW-1:0] tg  [NW+1];
  logic          v   [NW+1];

  always_comb begin
    q[0] = num;
    rem[0] = '0;
    d[0] = den;
    tg[0] = tag_in;
    v[0] = in_valid;
  end

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [DW+1:0] trial;
    assign trial = {rem[s], q[s][NW-1]};
    always_ff @(posedge clk) begin
      if (rst) v[s+1] <= 1'b0;
      else v[s+1] <= v[s];
      if (trial >= {2'b00, d[s]}) begin
        rem[s+1] <= (DW+1)'(trial - {2'b00, d[s]});
        q[s+1] <= {q[s][NW-2:0], 1'b1};
      end else begin
        rem[s+1] <= trial[DW:0];
        q[s+1] <= {q[s][NW-2:0], 1'b0};
      end
      d[s+1] <= d[s];
      tg[s+1] <= tg[s];
    end
  end

  assign out_valid = v[NW];
  assign quot = q[NW];
  assign tag_out = tg[NW];

endmodule

// File: rtl/rtpc_back.sv
// Back part: pressure formula through a pipelined divider, then output scaling.
// Depends on rtpc_pkg and rtpc_div.
`timescale 1ns / 1ps
module rtpc_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  rtpc_pkg::item_t item,
  input  logic [11:0]     plate,
  input  logic [11:0]     scr_w,
  input  logic [11:0]     scr_h,
  input  logic [9:0]      pfs,
  output logic            done,
  output logic [11:0]     x_pos,
  output logic [11:0]     y_pos,
  output logic [15:0]     pressure,
  output logic            point_valid
);

  // stage 1: |z2-z1|*x, sign, denominator
  logic        s1_v, s1_ok, s1_z0, s1_neg, s1_diffmode;
  logic [9:0]  s1_x, s1_y, s1_ad;
  logic [19:0] s1_px;
  logic [19:0] s1_den;
  logic [11:0] s1_plate;
  logic [9:0]  ad;

  assign ad = (item.z2 >= item.z1) ? item.z2 - item.z1 : item.z1 - item.z2;

  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else s1_v <= in_valid;
    s1_ok <= item.ok;
    s1_z0 <= item.z1_zero;
    s1_neg <= item.z1 > item.z2;
    s1_diffmode <= (plate == 12'd0);
    s1_x <= item.x;
    s1_y <= item.y;
    s1_ad <= ad;
    s1_px <= ad * item.x;
    s1_den <= {item.z1, 10'd0};
    s1_plate <= plate;
  end

  // stage 2: times plate
  logic        s2_v;
  logic [31:0] s2_num;
  logic [19:0] s2_den;
  localparam int TW = 1 + 1 + 1 + 1 + 10 + 10 + 10;
  logic [TW-1:0] s2_tag;

  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else s2_v <= s1_v;
    s2_num <= s1_px * s1_plate;
    s2_den <= s1_den;
    s2_tag <= {s1_ok, s1_z0, s1_neg, s1_diffmode, s1_x, s1_y, s1_ad};
  end

  logic          dv;
  logic [31:0]   dq;
  logic [TW-1:0] dt;

  rtpc_div #(.NW(32), .DW(20), .TW(TW)) u_div (
    .clk(clk), .rst(rst), .in_valid(s2_v), .num(s2_num),
    .den((s2_den == 20'd0) ? 20'd1 : s2_den), .tag_in(s2_tag),
    .out_valid(dv), .quot(dq), .tag_out(dt)
  );

  logic       t_ok, t_z0, t_neg, t_dm;
  logic [9:0] t_x, t_y, t_ad;
  assign {t_ok, t_z0, t_neg, t_dm, t_x, t_y, t_ad} = dt;

  // stage 3: saturate and form pressure code
  logic [15:0] zc;
  logic [15:0] mag;
  always_comb begin
    mag = (dq > 32'd32767) ? 16'd32767 : dq[15:0];
    if (t_neg && dq > 32'd32767) mag = 16'd32768;
    if (t_z0) zc = 16'd0;
    else if (t_dm) zc = 16'd1023 - {6'd0, t_ad};
    else if (t_neg) zc = 16'd1023 + mag;
    else if (mag > 16'd1023) zc = mag - 16'd1023;
    else zc = 16'd1023 - mag;
  end

  logic        s3_v, s3_ok;
  logic [21:0] s3_xp, s3_yp;
  logic [25:0] s3_zp;
  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else s3_v <= dv;
    s3_ok <= t_ok;
    s3_xp <= t_x * scr_w;
    s3_yp <= t_y * scr_h;
    s3_zp <= zc * pfs;
  end

  // divide by 1023: q = (p*1025) >> 20 as a reciprocal estimate, then fix by one
  function automatic logic [25:0] div1023(input logic [25:0] p);
    logic [26:0] qe;
    logic [36:0] back;
    qe = 27'((37'(p) * 37'd1025) >> 20);
    back = 37'(qe) * 37'd1023;
    if (back > 37'(p)) qe = qe - 27'd1;
    else if (37'(p) - back >= 37'd1023) qe = qe + 27'd1;
    return qe[25:0];
  endfunction

  logic [25:0] qx, qy, qz;
  assign qx = div1023({4'd0, s3_xp});
  assign qy = div1023({4'd0, s3_yp});
  assign qz = div1023(s3_zp);

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= s3_v;
    x_pos <= s3_ok ? qx[11:0] : 12'd0;
    y_pos <= s3_ok ? qy[11:0] : 12'd0;
    pressure <= s3_ok ? qz[15:0] : 16'd0;
    point_valid <= s3_ok;
  end

endmodule

// File: rtl/resistive_touch_point_calc.sv
// Top level of the resistive touch point calculator.
// Depends on rtpc_pkg, rtpc_front, rtpc_queue, rtpc_back.
`timescale 1ns / 1ps
// Usage:
//   Drive the six samples and pulse start; a set is taken on any cycle with
//   start high and busy low. One set may enter every cycle while busy is low.
//   Each result appears for one cycle with done high on x_pos, y_pos,
//   pressure and point_valid, in input order. The path runs through one
//   front register, the queue, two multiply stages, a 32-stage divider for
//   the touch resistance, and two scaling stages.
//   Throughput is one set per cycle while busy is low, set by the fully pipelined divider.
//   The receiver cannot stall; the back part always drains its queue, so
//   busy stays low in normal use and rises only if the queue were full.
//   Configuration: write cfg_we with cfg_addr as the register index and
//   cfg_data; writes take effect at once and belong between sets.
//   Reset (rst, synchronous) restores register defaults and empties the
//   pipeline and queue.
module resistive_touch_point_calc #(
  parameter int QueueDepth = rtpc_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [9:0]  x_sample_first,
  input  logic [9:0]  x_sample_second,
  input  logic [9:0]  y_sample_first,
  input  logic [9:0]  y_sample_second,
  input  logic [9:0]  z_one_sample,
  input  logic [9:0]  z_two_sample,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [11:0] cfg_data,
  output logic        done,
  output logic [11:0] x_pos,
  output logic [11:0] y_pos,
  output logic [15:0] pressure,
  output logic        point_valid
);

  logic [11:0] plate, scr_w, scr_h;
  logic [9:0]  tol, pfs;

  always_ff @(posedge clk) begin
    if (rst) begin
      plate <= rtpc_pkg::PlateReset;
      tol <= rtpc_pkg::TolReset;
      scr_w <= rtpc_pkg::WidthReset;
      scr_h <= rtpc_pkg::HeightReset;
      pfs <= rtpc_pkg::PfsReset;
    end else if (cfg_we) begin
      case (cfg_addr)
        rtpc_pkg::RegPlate:  plate <= cfg_data;
        rtpc_pkg::RegTol:    tol <= cfg_data[9:0];
        rtpc_pkg::RegWidth:  scr_w <= cfg_data;
        rtpc_pkg::RegHeight: scr_h <= cfg_data;
        rtpc_pkg::RegPfs:    pfs <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  logic            f_v, q_ne, q_full;
  rtpc_pkg::item_t f_item, q_item;

  assign busy = q_full;

  rtpc_front u_front (
    .clk(clk), .rst(rst), .start(start && !busy),
    .x_sample_first(x_sample_first), .x_sample_second(x_sample_second),
    .y_sample_first(y_sample_first), .y_sample_second(y_sample_second),
    .z_one_sample(z_one_sample), .z_two_sample(z_two_sample),
    .tol(tol), .item_valid(f_v), .item(f_item)
  );

  // back part never stalls, so pop whenever a beat is waiting
  rtpc_queue #(.Depth(QueueDepth)) u_queue (
    .clk(clk), .rst(rst), .push(f_v), .din(f_item), .pop(q_ne),
    .not_empty(q_ne), .full(q_full), .dout(q_item)
  );

  rtpc_back u_back (
    .clk(clk), .rst(rst), .in_valid(q_ne), .item(q_item),
    .plate(plate), .scr_w(scr_w), .scr_h(scr_h), .pfs(pfs),
    .done(done), .x_pos(x_pos), .y_pos(y_pos), .pressure(pressure),
    .point_valid(point_valid)
  );

endmodule

// File: rtl/rtpc_checker.sv
// Port checker for the resistive touch point calculator, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
module rtpc_checker (
  input logic        clk,
  input logic        rst,
  input logic        busy,
  input logic        done,
  input logic [11:0] x_pos,
  input logic [11:0] y_pos,
  input logic [15:0] pressure,
  input logic        point_valid
);

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    done && !point_valid |-> x_pos == 12'd0 && y_pos == 12'd0 && pressure == 16'd0)
    else $error("invalid point with nonzero fields");

  a_press_range: assert property (@(posedge clk) disable iff (rst)
    done |-> pressure <= 16'd33791)
    else $error("pressure out of range");

  a_reset_quiet: assert property (@(posedge clk) $past(rst) |-> !done)
    else $error("result right after reset");

  a_not_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("queue filled");

endmodule

bind resistive_touch_point_calc rtpc_checker u_rtpc_checker (
  .clk(clk), .rst(rst), .busy(busy), .done(done), .x_pos(x_pos),
  .y_pos(y_pos), .pressure(pressure), .point_valid(point_valid)
);

// File: test/tb_resistive_touch_point_calc.sv
// Testbench for resistive_touch_point_calc: directed and random measurement sets
// checked against a behavioral point/pressure predictor. Depends on rtpc_pkg.
`timescale 1ns / 1ps

class touch_scoreboard;
  logic [11:0] exp_x[$];
  logic [11:0] exp_y[$];
  logic [15:0] exp_p[$];
  logic        exp_v[$];
  int errors = 0;

  function void note_set(logic [11:0] xe, logic [11:0] ye, logic [15:0] pe, logic ve);
    exp_x.push_back(xe);
    exp_y.push_back(ye);
    exp_p.push_back(pe);
    exp_v.push_back(ve);
  endfunction

  function void check_point(logic [11:0] xa, logic [11:0] ya, logic [15:0] pa, logic va);
    logic [11:0] xe;
    logic [11:0] ye;
    logic [15:0] pe;
    logic ve;
    if (exp_x.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result x=%0d y=%0d p=%0d v=%0d", xa, ya, pa, va);
      return;
    end
    xe = exp_x.pop_front();
    ye = exp_y.pop_front();
    pe = exp_p.pop_front();
    ve = exp_v.pop_front();
    if (xa !== xe || ya !== ye || pa !== pe || va !== ve) begin
      errors++;
      if (errors <= 10)
        $display("mismatch exp x=%0d y=%0d p=%0d v=%0d got x=%0d y=%0d p=%0d v=%0d",
                 xe, ye, pe, ve, xa, ya, pa, va);
    end
  endfunction

  function int pending();
    return exp_x.size();
  endfunction
endclass

module tb_resistive_touch_point_calc;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic [9:0] xa = 0, xb = 0, ya = 0, yb = 0, z1 = 0, z2 = 0;
  logic cfg_we = 0;
  logic [2:0] cfg_addr = rtpc_pkg::RegPlate;
  logic [11:0] cfg_data = 0;
  logic done;
  logic [11:0] x_pos, y_pos;
  logic [15:0] pressure;
  logic point_valid;

  logic [11:0] plate, wid, hgt;
  logic [9:0] tol, pfs;
  int idle_cycles = 0;
  bit no_idle = 0;
  touch_scoreboard sb;

  resistive_touch_point_calc dut (
    .clk, .rst, .start, .busy,
    .x_sample_first(xa), .x_sample_second(xb),
    .y_sample_first(ya), .y_sample_second(yb),
    .z_one_sample(z1), .z_two_sample(z2),
    .cfg_we, .cfg_addr, .cfg_data,
    .done, .x_pos, .y_pos, .pressure, .point_valid
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [31:0] adiff(logic [31:0] a, logic [31:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [31:0] touch_pressure(logic [31:0] x, logic [31:0] s1,
                                                 logic [31:0] s2);
    longint num, den, r;
    if (s1 == 0) return 0;
    if (plate == 0) return rtpc_pkg::FullCode - adiff(s1, s2);
    num = (longint'(s2) - longint'(s1)) * longint'(x) * longint'(plate);
    den = longint'(s1) * 1024;
    r = num / den;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    r = rtpc_pkg::FullCode - r;
    if (r < 0) r = -r;
    return r[31:0];
  endfunction

  task automatic predict_point(logic [9:0] a0, b0, a1, b1, s1, s2);
    logic [31:0] x, y, z;
    logic [63:0] t;
    if (adiff(a0, b0) > tol || adiff(a1, b1) > tol) begin
      sb.note_set(0, 0, 0, 0);
      return;
    end
    x = rtpc_pkg::FullCode - b0;
    y = rtpc_pkg::FullCode - b1;
    z = touch_pressure(x, s1, s2);
    t = z * pfs / rtpc_pkg::FullCode;
    sb.note_set(12'((x * wid) / rtpc_pkg::FullCode), 12'((y * hgt) / rtpc_pkg::FullCode),
                t[15:0], 1'b1);
  endtask

  // One write beat, then a pause with cfg_we low before the next write.
  task automatic write_reg(logic [2:0] idx, logic [11:0] val);
    cfg_we <= 1; cfg_addr <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      rtpc_pkg::RegPlate: plate = val;
      rtpc_pkg::RegTol: tol = val[9:0];
      rtpc_pkg::RegWidth: wid = val;
      rtpc_pkg::RegHeight: hgt = val;
      rtpc_pkg::RegPfs: pfs = val[9:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic wait_drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  // Hold the beat until the block takes it, with optional idle burst first.
  task automatic send_set(logic [9:0] a0, b0, a1, b1, s1, s2);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    start <= 1; xa <= a0; xb <= b0; ya <= a1; yb <= b1; z1 <= s1; z2 <= s2;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_point(a0, b0, a1, b1, s1, s2);
  endtask

  task automatic end_burst();
    start <= 0;
    @(posedge clk);
  endtask

  // Mostly agreeing pairs with random content, some disagreeing noise.
  task automatic random_set();
    logic [9:0] a0, b0, a1, b1, s1, s2;
    int d;
    b0 = $urandom; b1 = $urandom;
    d = (tol > 20) ? 20 : tol;
    a0 = b0 + $urandom_range(0, 2 * d) - d;
    a1 = b1 + $urandom_range(0, 2 * d) - d;
    if ($urandom_range(0, 7) == 0) a0 = $urandom;
    if ($urandom_range(0, 7) == 0) a1 = $urandom;
    s1 = ($urandom_range(0, 15) == 0) ? 10'd0 : 10'($urandom);
    s2 = $urandom;
    if ($urandom_range(0, 3) == 0) s1 = $urandom_range(1, 8);
    send_set(a0, b0, a1, b1, s1, s2);
  endtask

  always @(posedge clk) begin
    if (!rst && done) sb.check_point(x_pos, y_pos, pressure, point_valid);
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("tb_resistive_touch_point_calc: FAIL");
      $finish;
    end
  end

  initial begin
    sb = new();
    plate = rtpc_pkg::PlateReset; tol = rtpc_pkg::TolReset; wid = rtpc_pkg::WidthReset;
    hgt = rtpc_pkg::HeightReset; pfs = rtpc_pkg::PfsReset;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: defaults, extremes, zero z1, invalid pairs
    send_set(0, 0, 0, 0, 0, 0);
    send_set(1023, 1023, 1023, 1023, 1023, 1023);
    send_set(0, 0, 0, 0, 1, 1023);
    send_set(5, 0, 5, 0, 1023, 0);
    send_set(500, 510, 300, 300, 0, 700);
    send_set(500, 511, 300, 300, 400, 700);
    send_set(300, 300, 200, 189, 400, 700);
    send_set(1023, 0, 0, 1023, 512, 512);
    send_set(10'h2AA, 10'h2AA, 10'h155, 10'h155, 10'h155, 10'h2AA);
    end_burst(); wait_drain();
    write_reg(rtpc_pkg::RegPlate, 4095); write_reg(rtpc_pkg::RegTol, 1023);
    write_reg(rtpc_pkg::RegWidth, 4095);
    write_reg(rtpc_pkg::RegHeight, 4095); write_reg(rtpc_pkg::RegPfs, 1023);
    send_set(1023, 0, 1023, 0, 1, 1023);
    send_set(0, 0, 0, 0, 1, 1023);
    send_set(0, 1023, 0, 1023, 1023, 1);
    send_set(0, 0, 0, 0, 1023, 1);
    send_set(0, 0, 0, 0, 0, 1023);
    end_burst(); wait_drain();
    write_reg(rtpc_pkg::RegPlate, 0); write_reg(rtpc_pkg::RegTol, 0);
    write_reg(rtpc_pkg::RegWidth, 1);
    write_reg(rtpc_pkg::RegHeight, 1); write_reg(rtpc_pkg::RegPfs, 1);
    send_set(0, 0, 0, 0, 1, 1023);
    send_set(7, 7, 9, 9, 1023, 1);
    send_set(7, 8, 9, 9, 5, 5);
    send_set(0, 0, 0, 0, 300, 300);
    end_burst(); wait_drain();
    write_reg(rtpc_pkg::RegWidth, 0); write_reg(rtpc_pkg::RegPfs, 0);
    send_set(0, 0, 0, 0, 300, 200);
    end_burst(); wait_drain();
    write_reg(3'd7, 12'hFFF);

    for (int ph = 0; ph < 11; ph++) begin
      if (ph == 10) no_idle = 1;
      if (ph == 0) begin
        write_reg(rtpc_pkg::RegPlate, rtpc_pkg::PlateReset);
        write_reg(rtpc_pkg::RegTol, 12'(rtpc_pkg::TolReset));
        write_reg(rtpc_pkg::RegWidth, rtpc_pkg::WidthReset);
        write_reg(rtpc_pkg::RegHeight, rtpc_pkg::HeightReset);
        write_reg(rtpc_pkg::RegPfs, 12'(rtpc_pkg::PfsReset));
      end else begin
        write_reg(rtpc_pkg::RegPlate, ($urandom_range(0, 3) == 0) ? 12'd0 : 12'($urandom));
        write_reg(rtpc_pkg::RegTol,
                  $urandom_range(0, 3) == 0 ? 12'($urandom) : 12'($urandom_range(0, 30)));
        write_reg(rtpc_pkg::RegWidth, 12'($urandom_range(1, 4095)));
        write_reg(rtpc_pkg::RegHeight, 12'($urandom_range(1, 4095)));
        write_reg(rtpc_pkg::RegPfs, 12'($urandom_range(1, 1023)));
      end
      for (int i = 0; i < 100; i++) random_set();
      end_burst(); wait_drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) $display("tb_resistive_touch_point_calc: PASS");
    else $display("tb_resistive_touch_point_calc: FAIL");
    $finish;
  end
endmodule

// File: files.f
rtl/rtpc_pkg.sv
rtl/rtpc_front.sv
rtl/rtpc_queue.sv
rtl/rtpc_div.sv
rtl/rtpc_back.sv
rtl/resistive_touch_point_calc.sv
rtl/rtpc_checker.sv
test/tb_resistive_touch_point_calc.sv
